// ===== rtl/wpve_pkg.sv =====
// Shared types, operation codes and the uintvar encoding function for the WSP primitive value encoder.
package wpve_pkg;

    localparam logic [2:0] FUNC_UINTVAR   = 3'd0;
    localparam logic [2:0] FUNC_VALUE_LEN = 3'd1;
    localparam logic [2:0] FUNC_SHORT_INT = 3'd2;
    localparam logic [2:0] FUNC_LONG_INT  = 3'd3;
    localparam logic [2:0] FUNC_INTEGER   = 3'd4;
    localparam logic [2:0] FUNC_QVALUE    = 3'd5;

    localparam int          MAX_BYTES      = 6;
    localparam int          UV_BYTES       = 5;
    localparam int          QDEPTH         = 2;
    localparam logic [31:0] SHORT_LEN_MAX  = 32'd30;
    localparam logic [7:0]  LEN_QUOTE_BYTE = 8'd31;
    localparam logic [31:0] SHORT_INT_LIM  = 32'd128;
    localparam logic [31:0] Q_SCALE        = 32'd1000;
    localparam logic [10:0] Q_OFFSET       = 11'd100;
    // floor(x / 10) == (x * 205) >> 11 for every x below 1029
    localparam logic [7:0]  DIV10_RECIP    = 8'd205;

    typedef struct packed {
        logic [UV_BYTES-1:0][7:0] b;
        logic [2:0]               n;
    } uv_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      err;
    } plan_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Uintvar: 7-bit groups, most significant first, continuation bit on all but the final one.
    function automatic uv_t uintvar_enc(input logic [31:0] v);
        uv_t              r;
        logic [4:0][6:0]  g;
        logic [2:0]       top;
        logic [2:0]       gi;
        g[0] = v[6:0];
        g[1] = v[13:7];
        g[2] = v[20:14];
        g[3] = v[27:21];
        g[4] = {3'b000, v[31:28]};
        top  = 3'd0;
        for (int i = 1; i < UV_BYTES; i++) begin
            if (g[i] != 7'd0) begin
                top = 3'(i);
            end
        end
        r.n = top + 3'd1;
        for (int j = 0; j < UV_BYTES; j++) begin
            r.b[j] = 8'h00;
            gi     = top - 3'(j);
            if (3'(j) <= top) begin
                r.b[j] = {(3'(j) != top), g[gi]};
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/wsp_primitive_value_encoder_top.sv =====
// Top level of the WSP primitive value encoder: front end, plan queue, byte sequencer.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------
//  input   | in_valid / in_stall  | func[2:0], operand[31:0]
//  output  | out_valid / out_stall| out_byte[7:0], last, error
//
// Each request with a used operation code yields one to six bytes; the output register
// moves one byte per cycle while out_stall lets it.
// A first byte passes the queue entry, the plan register and then the output register
// before out_valid shows it.
// rst_n clears the queue pointers and all valid flags at once; no clearing pass.
// in_stall rises only while the two-entry plan queue is full; out_stall holds the
// output register and, once the queue fills, backs up to the input.
// Unused operation codes are accepted and dropped with no output.
module wsp_primitive_value_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [31:0] operand,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic        error
);
    import wpve_pkg::*;

    plan_t     push_plan;
    plan_t     head_plan;
    q_status_t q_status;
    logic      push;
    logic      pop;

    // Classify the request and build its byte plan in the cycle it is accepted.
    wpve_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .operand   (operand),
        .q_status  (q_status),
        .push      (push),
        .push_plan (push_plan)
    );

    // Hold up to two plans so the front keeps accepting while the back drains.
    wpve_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_plan (push_plan),
        .pop       (pop),
        .pop_plan  (head_plan),
        .status    (q_status)
    );

    // Advance through the plan, one byte per cycle whenever the output register frees.
    wpve_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head_plan (head_plan),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last),
        .error     (error)
    );

endmodule

// ===== rtl/wpve_front.sv =====
// Front end: accepts requests and turns each into a plan of up to six bytes.
module wpve_front (
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        func,
    input  logic [31:0]       operand,
    input  wpve_pkg::q_status_t q_status,
    output logic              push,
    output wpve_pkg::plan_t   push_plan
);
    import wpve_pkg::*;

    plan_t            plan;
    uv_t              uv_op;
    uv_t              uv_q;
    logic [3:0][7:0]  vb;
    logic [2:0]       nb;
    logic [1:0]       sel;
    logic [9:0]       q10;
    logic [17:0]      qprod;
    logic [6:0]       qdiv;
    logic [9:0]       qrem;
    logic [10:0]      qval;
    logic             q_bad;
    logic             use_short;

    assign vb    = operand;
    assign uv_op = uintvar_enc(operand);

    // q-value: operand known below 1000 when used, so ten bits suffice
    assign q10   = operand[9:0];
    assign q_bad = (operand == 32'd0) || (operand >= Q_SCALE);
    assign qprod = 18'(q10) * 18'(DIV10_RECIP);
    assign qdiv  = qprod[17:11];
    assign qrem  = q10 - 10'(qdiv) * 10'd10;
    assign qval  = (qrem == 10'd0) ? (11'(qdiv) + 11'd1) : (11'(q10) + Q_OFFSET);
    assign uv_q  = uintvar_enc(32'(qval));

    assign use_short = (func == FUNC_SHORT_INT)
                       || ((func == FUNC_INTEGER) && (operand < SHORT_INT_LIM));

    always_comb
    begin
        nb = 3'd1;
        if (operand > 32'h0000_00ff) nb = 3'd2;
        if (operand > 32'h0000_ffff) nb = 3'd3;
        if (operand > 32'h00ff_ffff) nb = 3'd4;
    end

    always_comb
    begin
        plan.bytes = '0;
        plan.count = 3'd0;
        plan.err   = 1'b0;
        sel        = 2'd0;
        unique case (func) inside
            FUNC_UINTVAR:
            begin
                plan.bytes[UV_BYTES-1:0] = uv_op.b;
                plan.count               = uv_op.n;
            end
            FUNC_VALUE_LEN:
            begin
                if (operand > SHORT_LEN_MAX) begin
                    plan.bytes[0]          = LEN_QUOTE_BYTE;
                    plan.bytes[UV_BYTES:1] = uv_op.b;
                    plan.count             = uv_op.n + 3'd1;
                end else begin
                    plan.bytes[0] = operand[7:0];
                    plan.count    = 3'd1;
                end
            end
            FUNC_SHORT_INT, FUNC_LONG_INT, FUNC_INTEGER:
            begin
                if (use_short) begin
                    plan.bytes[0] = {1'b1, operand[6:0]};
                    plan.count    = 3'd1;
                end else begin
                    plan.bytes[0] = 8'(nb);
                    for (int k = 0; k < 4; k++) begin
                        sel = 2'(nb - 3'd1 - 3'(k));
                        if (3'(k) < nb) begin
                            plan.bytes[k+1] = vb[sel];
                        end
                    end
                    plan.count = nb + 3'd1;
                end
            end
            FUNC_QVALUE:
            begin
                if (q_bad) begin
                    plan.count = 3'd1;
                    plan.err   = 1'b1;
                end else begin
                    plan.bytes[UV_BYTES-1:0] = uv_q.b;
                    plan.count               = uv_q.n;
                end
            end
            default:
            begin
                plan.count = 3'd0;
            end
        endcase
    end

    // Drop unused codes here: they yield no bytes and never enter the queue.
    assign in_stall  = q_status.full;
    assign push      = in_valid && !q_status.full && (plan.count != 3'd0);
    assign push_plan = plan;

endmodule

// ===== rtl/wpve_queue.sv =====
// Two-entry plan queue between the front end and the byte sequencer.
module wpve_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wpve_pkg::plan_t     push_plan,
    input  logic                pop,
    output wpve_pkg::plan_t     pop_plan,
    output wpve_pkg::q_status_t status
);
    import wpve_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    plan_t         entry_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign status.full  = (cnt_reg == CW'(QDEPTH));
    assign status.empty = (cnt_reg == '0);
    assign pop_plan     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_plan;
        end
    end

endmodule

// ===== rtl/wpve_back.sv =====
// Back end: walks the current plan one byte per cycle into the output register while out_stall lets it.
module wpve_back (
    input  logic                clk,
    input  logic                rst_n,
    input  wpve_pkg::q_status_t q_status,
    input  wpve_pkg::plan_t     head_plan,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic                last,
    output logic                error
);
    import wpve_pkg::*;

    plan_t      cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       last_reg;
    logic       error_reg;
    logic       advance;
    logic       emit;
    logic       final_byte;
    logic       finish;

    assign advance    = !out_valid_reg || !out_stall;
    assign emit       = advance && cur_valid_reg;
    assign final_byte = (idx_reg == cur_reg.count - 3'd1);
    assign finish     = emit && final_byte;
    // Load the next plan when idle or as the current one hands off its final byte.
    assign pop        = !q_status.empty && (!cur_valid_reg || finish);

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop) begin
            cur_next       = head_plan;
            cur_valid_next = 1'b1;
            idx_next       = 3'd0;
        end else if (finish) begin
            cur_valid_next = 1'b0;
        end else if (emit) begin
            idx_next = idx_reg + 3'd1;
        end
        out_valid_next = advance ? cur_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit) begin
            out_byte_reg <= cur_reg.bytes[idx_reg];
            last_reg     <= final_byte;
            error_reg    <= cur_reg.err;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign error     = error_reg;

endmodule

// ===== rtl/wpve_checker.sv =====
// Port-level checker for the WSP primitive value encoder, bound to the top level.
module wpve_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       last,
    input logic       error
);

    // A stalled output request holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last)
                                   && $stable(error))
        else $error("output request changed while stalled");

    // An error result is a single zero byte.
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last && (out_byte == 8'h00))
        else $error("error result not a lone zero byte");

    // Bytes of a request follow each other with no gap.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && !error)
        else $error("gap or error inside a multi-byte encoding");

    // A result that is not the final byte carries continuation data, never error.
    a_err_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !error)
        else $error("error flagged on a non-final byte");

endmodule

bind wsp_primitive_value_encoder_top wpve_checker u_wpve_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last),
    .error     (error)
);
